// File: design/cea_pkg.sv
// ---------------------------------------------------------------------------
// Circular extent allocator package
// Shared state encoding, request and status codes, and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package cea_pkg;

   // Request kinds, carried on the request channel's tuser.
   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CSR_EXTENT_LENGTH = 1'b0;
   localparam logic [0:0] CSR_WRAP_MODE     = 1'b1;

   localparam logic [7:0] EXTENT_LENGTH_RESET = 8'd15;

   // Result field positions inside rsp_tdata.
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_START_LSB  = 2;
   localparam int RSP_BLOCKS_LSB = 9;
   localparam int RSP_USED_LSB   = 17;
   localparam int RSP_FREE_LSB   = 18;
   localparam int RSP_DATA_W     = 32;

   typedef enum logic [2:0] {
      ST_CLR_GO,
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_REL_TAKE,
      ST_QRY_TAKE,
      ST_MARK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: design/cea_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/cea_walker.sv
// ---------------------------------------------------------------------------
// Ring range walker
// Steps a block position around the ring once per cycle for a loaded count,
// giving the write address for bitmap marking and for the clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module cea_walker #(
   parameter int RING_BLOCKS = 128
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            start,
   input  wire logic [((RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1)-1:0] first,
   input  wire logic [$clog2(RING_BLOCKS + 1)-1:0]              count,
   output logic                                                 active,
   output logic [((RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1)-1:0] addr
);

   localparam int AW = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
   localparam int CW = $clog2(RING_BLOCKS + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(RING_BLOCKS - 1);

   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] left_ff, left_in;

   always_comb begin
      pos_in  = pos_ff;
      left_in = left_ff;
      if (start) begin
         pos_in  = first;
         left_in = count;
      end else if (left_ff != '0) begin
         // The one shared incrementer: next block around the ring.
         pos_in  = (pos_ff == LAST_POS) ? '0 : pos_ff + AW'(1);
         left_in = left_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      pos_ff <= pos_in;
   end

   assign active = (left_ff != '0);
   assign addr   = pos_ff;

endmodule

`default_nettype wire

// File: design/circular_extent_allocator.sv
// ---------------------------------------------------------------------------
// Circular extent allocator
// Hands out extents of a ring of blocks in FIFO order, keeps a used bitmap,
// and answers allocate, release and query requests one at a time.
// ---------------------------------------------------------------------------
// Usage:
//   A request is one transfer on req_*: tuser carries the kind (allocate,
//   release oldest extent, query) and tdata the block index for a query.
//   Every request yields exactly one result transfer on rsp_*.
//   Configuration (extent length, wrap mode) is written on csr_* while no
//   request is in flight; a write takes effect at the next clock edge.
// Sequencing:
//   req_tready is high only while the block is idle. After the request
//   transfer a decide state settles a request that changes nothing; a query
//   then reads the used bitmap, an allocation marks its G blocks and a release
//   of N blocks first reads the extent length from the extent table RAM and
//   then clears them: the range walker updates one bitmap bit per cycle. The
//   next request can transfer in the cycle after the result transfer.
// Reset:
//   After reset the walker sweeps both RAMs to clear the bitmap and the extent
//   table; req_tready stays low for the whole of that pass.
// Back-pressure:
//   A result stays in the output register, unchanged, until rsp_tready takes
//   it; the block accepts the next request only after that transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_extent_allocator #(
   parameter int RING_BLOCKS = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [6:0] query_index, [7] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] mode
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [1:0] status, [8:2] start_block,
                                         // [16:9] extent_blocks, [17] block_used,
                                         // [25:18] free_blocks, [31:26] zero
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   localparam int AW = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
   localparam int CW = $clog2(RING_BLOCKS + 1);
   localparam int XW = ((CW > 8) ? CW : 8) + 1;
   localparam logic [CW-1:0] RING_COUNT = CW'(RING_BLOCKS);
   localparam logic [XW-1:0] RING_X     = XW'(RING_BLOCKS);

   // Configuration registers.
   logic [7:0] ext_len_ff;
   logic       wrap_ff;

   // Control state.
   cea_pkg::state_type state_ff, state_in;
   logic [AW-1:0] alloc_ptr_ff, alloc_ptr_in;
   logic [AW-1:0] rel_ptr_ff, rel_ptr_in;
   logic [CW-1:0] used_cnt_ff, used_cnt_in;

   // Captured request and result payload.
   logic [1:0] mode_ff;
   logic [6:0] qidx_ff;
   logic       mark_bit_ff, mark_bit_in;
   logic [1:0] status_ff, status_in;
   logic [6:0] start_ff, start_in;
   logic [7:0] blocks_ff, blocks_in;
   logic       used_ff, used_in;

   // Walker and RAM connections.
   logic          walk_start;
   logic [AW-1:0] walk_first;
   logic [CW-1:0] walk_count;
   logic          walk_active;
   logic [AW-1:0] walk_addr;
   logic          map_we;
   logic [0:0]    map_rdata;
   logic          tbl_we;
   logic [AW-1:0] tbl_waddr;
   logic [7:0]    tbl_wdata;
   logic [7:0]    tbl_rdata;

   // Datapath terms, all from registered values.
   logic [7:0]    want;
   logic [CW-1:0] free_now;
   logic          no_space;
   logic          past_end;
   logic [7:0]    grant;
   logic [XW-1:0] alloc_sum;
   logic [XW-1:0] rel_n;
   logic [XW-1:0] rel_sum;
   logic          q_in_ring;
   logic [AW-1:0] q_addr;

   logic req_xfer;
   logic rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   assign want      = (ext_len_ff == 8'd0) ? 8'd1 : ext_len_ff;
   assign free_now  = RING_COUNT - used_cnt_ff;
   assign no_space  = XW'(free_now) < XW'(want);
   assign past_end  = (XW'(alloc_ptr_ff) + XW'(want)) > RING_X;
   assign grant     = (!wrap_ff && past_end) ? 8'd1 : want;
   // A granted extent never exceeds the ring, so one subtract folds it back.
   assign alloc_sum = XW'(alloc_ptr_ff) + XW'(grant);
   assign rel_n     = (XW'(tbl_rdata) > XW'(used_cnt_ff)) ? XW'(used_cnt_ff)
                                                          : XW'(tbl_rdata);
   assign rel_sum   = XW'(rel_ptr_ff) + rel_n;
   assign q_in_ring = 32'(qidx_ff) < RING_BLOCKS;
   assign q_addr    = AW'(qidx_ff);

   always_comb begin
      state_in     = state_ff;
      alloc_ptr_in = alloc_ptr_ff;
      rel_ptr_in   = rel_ptr_ff;
      used_cnt_in  = used_cnt_ff;
      mark_bit_in  = mark_bit_ff;
      status_in    = status_ff;
      start_in     = start_ff;
      blocks_in    = blocks_ff;
      used_in      = used_ff;
      walk_start   = 1'b0;
      walk_first   = alloc_ptr_ff;
      walk_count   = CW'(grant);
      tbl_we       = 1'b0;
      tbl_waddr    = alloc_ptr_ff;
      tbl_wdata    = grant;

      case (state_ff)
         cea_pkg::ST_CLR_GO: begin
            walk_start  = 1'b1;
            walk_first  = '0;
            walk_count  = RING_COUNT;
            mark_bit_in = 1'b0;
            state_in    = cea_pkg::ST_CLEAR;
         end
         cea_pkg::ST_CLEAR: begin
            tbl_we    = walk_active;
            tbl_waddr = walk_addr;
            tbl_wdata = 8'd0;
            if (!walk_active) begin
               state_in = cea_pkg::ST_IDLE;
            end
         end
         cea_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = cea_pkg::ST_DECIDE;
            end
         end
         cea_pkg::ST_DECIDE: begin
            status_in = cea_pkg::STATUS_DONE;
            start_in  = 7'd0;
            blocks_in = 8'd0;
            used_in   = 1'b0;
            state_in  = cea_pkg::ST_RESP;
            case (mode_ff)
               cea_pkg::MODE_ALLOC: begin
                  start_in = 7'(alloc_ptr_ff);
                  if (no_space) begin
                     status_in = cea_pkg::STATUS_NO_SPACE;
                  end else begin
                     tbl_we       = 1'b1;
                     walk_start   = 1'b1;
                     mark_bit_in  = 1'b1;
                     blocks_in    = grant;
                     alloc_ptr_in = (alloc_sum >= RING_X) ? AW'(alloc_sum - RING_X)
                                                          : AW'(alloc_sum);
                     used_cnt_in  = used_cnt_ff + CW'(grant);
                     state_in     = cea_pkg::ST_MARK;
                  end
               end
               cea_pkg::MODE_RELEASE: begin
                  start_in = 7'(rel_ptr_ff);
                  if (used_cnt_ff == '0) begin
                     status_in = cea_pkg::STATUS_EMPTY;
                  end else begin
                     // The extent table read of the oldest start is in flight.
                     state_in = cea_pkg::ST_REL_TAKE;
                  end
               end
               cea_pkg::MODE_QUERY: begin
                  state_in = cea_pkg::ST_QRY_TAKE;
               end
               default: begin
                  state_in = cea_pkg::ST_RESP;
               end
            endcase
         end
         cea_pkg::ST_REL_TAKE: begin
            walk_start  = 1'b1;
            walk_first  = rel_ptr_ff;
            walk_count  = CW'(rel_n);
            mark_bit_in = 1'b0;
            blocks_in   = 8'(rel_n);
            rel_ptr_in  = (rel_sum >= RING_X) ? AW'(rel_sum - RING_X) : AW'(rel_sum);
            used_cnt_in = used_cnt_ff - CW'(rel_n);
            state_in    = cea_pkg::ST_MARK;
         end
         cea_pkg::ST_QRY_TAKE: begin
            used_in  = q_in_ring && map_rdata[0];
            state_in = cea_pkg::ST_RESP;
         end
         cea_pkg::ST_MARK: begin
            if (!walk_active) begin
               state_in = cea_pkg::ST_RESP;
            end
         end
         cea_pkg::ST_RESP: begin
            if (rsp_xfer) begin
               state_in = cea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cea_pkg::ST_CLR_GO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cea_pkg::ST_CLR_GO;
         alloc_ptr_ff <= '0;
         rel_ptr_ff   <= '0;
         used_cnt_ff  <= '0;
         ext_len_ff   <= cea_pkg::EXTENT_LENGTH_RESET;
         wrap_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alloc_ptr_ff <= alloc_ptr_in;
         rel_ptr_ff   <= rel_ptr_in;
         used_cnt_ff  <= used_cnt_in;
         if (csr_we) begin
            case (csr_addr)
               cea_pkg::CSR_EXTENT_LENGTH: ext_len_ff <= csr_wdata;
               cea_pkg::CSR_WRAP_MODE:     wrap_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff <= req_tuser;
         qidx_ff <= req_tdata[6:0];
      end
      mark_bit_ff <= mark_bit_in;
      status_ff   <= status_in;
      start_ff    <= start_in;
      blocks_ff   <= blocks_in;
      used_ff     <= used_in;
   end

   cea_walker #(
      .RING_BLOCKS(RING_BLOCKS)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .first (walk_first),
      .count (walk_count),
      .active(walk_active),
      .addr  (walk_addr)
   );

   // Used bitmap: written by the walker, read only for queries.
   assign map_we = walk_active && (state_ff == cea_pkg::ST_MARK ||
                                   state_ff == cea_pkg::ST_CLEAR);

   cea_ram #(
      .WIDTH(1),
      .DEPTH(RING_BLOCKS)
   ) u_used_map (
      .clock(clock),
      .we   (map_we),
      .waddr(walk_addr),
      .wdata(mark_bit_ff),
      .raddr(q_addr),
      .rdata(map_rdata)
   );

   // Extent table: length stored at each extent's first block, read at the
   // release pointer.
   cea_ram #(
      .WIDTH(8),
      .DEPTH(RING_BLOCKS)
   ) u_extent_table (
      .clock(clock),
      .we   (tbl_we),
      .waddr(tbl_waddr),
      .wdata(tbl_wdata),
      .raddr(rel_ptr_ff),
      .rdata(tbl_rdata)
   );

   assign req_tready = (state_ff == cea_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == cea_pkg::ST_RESP);
   assign rsp_tdata  = {6'd0, 8'(RING_COUNT - used_cnt_ff), used_ff, blocks_ff,
                        start_ff, status_ff};

endmodule

`default_nettype wire

// File: design/cea_checker.sv
// ---------------------------------------------------------------------------
// Circular extent allocator port checker
// Watches the top level's ports for ordering and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module cea_checker #(
   parameter int RING_BLOCKS = 128
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic [1:0] rsp_status;
   logic [7:0] rsp_blocks;
   logic       rsp_used;
   logic [7:0] rsp_free;

   assign rsp_status = rsp_tdata[cea_pkg::RSP_STATUS_LSB +: 2];
   assign rsp_blocks = rsp_tdata[cea_pkg::RSP_BLOCKS_LSB +: 8];
   assign rsp_used   = rsp_tdata[cea_pkg::RSP_USED_LSB];
   assign rsp_free   = rsp_tdata[cea_pkg::RSP_FREE_LSB +: 8];

   // A waiting result keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One request at a time: no new request while a result is pending.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

   // After a request transfer the block is busy on the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after a request");

   // A refused request moves no blocks and reports no used bit.
   a_refusal_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == cea_pkg::STATUS_NO_SPACE ||
                     rsp_status == cea_pkg::STATUS_EMPTY)
      |-> rsp_blocks == 8'd0 && !rsp_used)
      else $error("refused request reports blocks");

   // An empty-ring release reports the whole ring free.
   a_empty_all_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == cea_pkg::STATUS_EMPTY
      |-> rsp_free == 8'(RING_BLOCKS))
      else $error("empty release with blocks in use");

endmodule

bind circular_extent_allocator cea_checker #(
   .RING_BLOCKS(RING_BLOCKS)
) u_cea_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire
